// ===== rtl/ctm_pkg.sv =====
`default_nettype none

package ctm_pkg;

    // Sizes of the pitch-class space and the template set.
    localparam int NUM_CLASSES = 12;
    localparam int NUM_TMPL    = 11;
    localparam int NUM_BINS    = 6;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_EXTRAS      = 3'd0,
        CFG_TONE_WEIGHT     = 3'd1,
        CFG_EXTRA_PENALTY   = 3'd2,
        CFG_CLEAN_BONUS     = 3'd3,
        CFG_BASS_BONUS      = 3'd4,
        CFG_INVERSION_BONUS = 3'd5
    } t_cfg_idx;

    // Register values after reset.
    localparam logic [3:0] RST_MAX_EXTRAS      = 4'd2;
    localparam logic [5:0] RST_TONE_WEIGHT     = 6'd20;
    localparam logic [5:0] RST_EXTRA_PENALTY   = 6'd8;
    localparam logic [5:0] RST_CLEAN_BONUS     = 6'd15;
    localparam logic [5:0] RST_BASS_BONUS      = 6'd6;
    localparam logic [5:0] RST_INVERSION_BONUS = 6'd4;

    typedef enum logic [1:0] {
        KIND_EMPTY     = 2'd0,
        KIND_SINGLE    = 2'd1,
        KIND_CHORD     = 2'd2,
        KIND_UNMATCHED = 2'd3
    } t_kind;

    typedef logic [3:0]          t_pclass;
    typedef logic [3:0]          t_quality;
    typedef logic signed [10:0]  t_score;

    // One bit per candidate: [root][template].
    typedef logic [NUM_CLASSES-1:0][NUM_TMPL-1:0] t_cand_grid;

    // First candidate found within one score bin.
    typedef struct packed {
        logic     found;
        t_pclass  root;
        t_quality quality;
    } t_pick;

    // Number of intervals above the root in each template.
    function automatic logic [1:0] tmpl_len(input t_quality q);
        logic [1:0] len;
        unique case (q)
            4'd0, 4'd1, 4'd2, 4'd3:                 len = 2'd3;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9:     len = 2'd2;
            default:                                len = 2'd1;
        endcase
        return len;
    endfunction

    // Intervals above the root; element 0 is the first interval.
    function automatic logic [2:0][3:0] tmpl_ivs(input t_quality q);
        logic [2:0][3:0] iv;
        unique case (q)
            4'd0:    iv = {4'd11, 4'd7, 4'd4};
            4'd1:    iv = {4'd10, 4'd7, 4'd3};
            4'd2:    iv = {4'd10, 4'd7, 4'd4};
            4'd3:    iv = {4'd10, 4'd6, 4'd3};
            4'd4:    iv = {4'd0,  4'd7, 4'd4};
            4'd5:    iv = {4'd0,  4'd7, 4'd3};
            4'd6:    iv = {4'd0,  4'd6, 4'd3};
            4'd7:    iv = {4'd0,  4'd8, 4'd4};
            4'd8:    iv = {4'd0,  4'd7, 4'd2};
            4'd9:    iv = {4'd0,  4'd7, 4'd5};
            default: iv = {4'd0,  4'd0, 4'd7};
        endcase
        return iv;
    endfunction

    // Sum of two pitch classes, wrapped into one octave.
    function automatic t_pclass pc_add(input t_pclass a, input t_pclass b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 5'd12) ? 4'(s - 5'd12) : s[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ctm_first.sv =====
`default_nettype none

// Priority pick: the lowest root, then the lowest template index, among the
// candidates flagged in one score bin.
module ctm_first (
    input  wire ctm_pkg::t_cand_grid i_cand,
    output ctm_pkg::t_pick           o_pick
);

    always_comb begin
        o_pick = '0;
        for (int r = ctm_pkg::NUM_CLASSES - 1; r >= 0; r--) begin
            for (int q = ctm_pkg::NUM_TMPL - 1; q >= 0; q--) begin
                if (i_cand[r][q]) begin
                    o_pick.found   = 1'b1;
                    o_pick.root    = 4'(r);
                    o_pick.quality = 4'(q);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/chord_template_matcher.sv =====
// Throughput: one item per cycle while the result side is not stalled; an item passes
// through the input register, candidate stage, bin-pick stage and result register in
// order, and each stage holds one item and advances independently.
// Reset (synchronous, active low) empties all stages and loads the scoring
// registers with their defaults; no clearing pass is needed.
`default_nettype none

module chord_template_matcher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration writes
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [5:0]  i_cfg_wdata,
    // Input items
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [11:0] i_held_mask,
    input  wire  [3:0]  i_bass_class,
    // Result items
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_root_class,
    output logic [3:0]  o_bass_out,
    output logic [3:0]  o_quality_code,
    output logic [1:0]  o_inversion,
    output logic [3:0]  o_tone_count,
    output logic signed [10:0] o_best_score
);

    // Scoring registers.
    logic [3:0] r_max_extras;
    logic [5:0] r_tone_weight;
    logic [5:0] r_extra_penalty;
    logic [5:0] r_clean_bonus;
    logic [5:0] r_bass_bonus;
    logic [5:0] r_inversion_bonus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_extras      <= ctm_pkg::RST_MAX_EXTRAS;
            r_tone_weight     <= ctm_pkg::RST_TONE_WEIGHT;
            r_extra_penalty   <= ctm_pkg::RST_EXTRA_PENALTY;
            r_clean_bonus     <= ctm_pkg::RST_CLEAN_BONUS;
            r_bass_bonus      <= ctm_pkg::RST_BASS_BONUS;
            r_inversion_bonus <= ctm_pkg::RST_INVERSION_BONUS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ctm_pkg::CFG_MAX_EXTRAS:      r_max_extras      <= i_cfg_wdata[3:0];
                ctm_pkg::CFG_TONE_WEIGHT:     r_tone_weight     <= i_cfg_wdata;
                ctm_pkg::CFG_EXTRA_PENALTY:   r_extra_penalty   <= i_cfg_wdata;
                ctm_pkg::CFG_CLEAN_BONUS:     r_clean_bonus     <= i_cfg_wdata;
                ctm_pkg::CFG_BASS_BONUS:      r_bass_bonus      <= i_cfg_wdata;
                ctm_pkg::CFG_INVERSION_BONUS: r_inversion_bonus <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when it is empty or moving on.
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic en1, en2, en3, en4;

    assign en4 = !r_out_valid || !i_stall;
    assign en3 = !r_s3_valid || en4;
    assign en2 = !r_s2_valid || en3;
    assign en1 = !r_s1_valid || en2;
    assign o_stall = !en1;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) r_s1_valid  <= i_valid;
            if (en2) r_s2_valid  <= r_s1_valid;
            if (en3) r_s3_valid  <= r_s2_valid;
            if (en4) r_out_valid <= r_s3_valid;
        end
    end

    // Stage 1: input register.
    logic [11:0] r_s1_mask;
    logic [3:0]  r_s1_bass;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_mask <= i_held_mask;
            r_s1_bass <= i_bass_class;
        end
    end

    // Stage 2: template matches, bass membership and per-bin scores.
    ctm_pkg::t_cand_grid n_s2_match, n_s2_bt;
    logic [3:0]          n_s2_held, n_s2_only, n_s2_bass;
    logic [2:0]          n_s2_allow;
    ctm_pkg::t_score     n_s2_score [ctm_pkg::NUM_BINS];

    // Bass reduced into one octave.
    assign n_s2_bass = (r_s1_bass >= 4'd12) ? 4'(r_s1_bass - 4'd12) : r_s1_bass;

    // Held count and the last held class (the note itself for a single note).
    always_comb begin
        n_s2_held = '0;
        n_s2_only = '0;
        for (int i = 0; i < ctm_pkg::NUM_CLASSES; i++) begin
            if (r_s1_mask[i]) begin
                n_s2_held = n_s2_held + 4'd1;
                n_s2_only = 4'(i);
            end
        end
    end

    // Each root against each template.
    always_comb begin
        logic [2:0][3:0] ivs;
        logic [1:0]      len;
        logic            all_held;
        logic            bass_hit;
        n_s2_match = '0;
        n_s2_bt    = '0;
        for (int r = 0; r < ctm_pkg::NUM_CLASSES; r++) begin
            for (int q = 0; q < ctm_pkg::NUM_TMPL; q++) begin
                ivs      = ctm_pkg::tmpl_ivs(4'(q));
                len      = ctm_pkg::tmpl_len(4'(q));
                all_held = r_s1_mask[r];
                bass_hit = (n_s2_bass == 4'(r));
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < len) begin
                        if (!r_s1_mask[ctm_pkg::pc_add(4'(r), ivs[k])]) begin
                            all_held = 1'b0;
                        end
                        if (ctm_pkg::pc_add(4'(r), ivs[k]) == n_s2_bass) begin
                            bass_hit = 1'b1;
                        end
                    end
                end
                n_s2_match[r][q] = all_held;
                n_s2_bt[r][q]    = bass_hit;
            end
        end
    end

    // The score depends only on the tone count and bass membership, so six
    // bins cover every candidate of an item. Bin = 2 * (tones - 2) + bass_hit.
    always_comb begin
        logic [2:0]  tones;
        logic [3:0]  extras;
        logic [8:0]  tone_pts;
        logic [9:0]  extra_pts;
        logic [11:0] base;
        for (int t = 0; t < 3; t++) begin
            tones     = 3'(t + 2);
            extras    = (n_s2_held >= 4'(tones)) ? 4'(n_s2_held - 4'(tones)) : 4'd0;
            tone_pts  = 9'(tones) * 9'(r_tone_weight);
            extra_pts = 10'(extras) * 10'(r_extra_penalty);
            base      = 12'(tone_pts) - 12'(extra_pts);
            if (extras == 4'd0) begin
                base = base + 12'(r_clean_bonus);
            end
            n_s2_allow[t]        = (n_s2_held >= 4'(tones)) && (extras <= r_max_extras);
            n_s2_score[2*t]      = base[10:0];
            n_s2_score[2*t + 1]  = 11'(base + 12'(r_bass_bonus) + 12'(r_inversion_bonus));
        end
    end

    ctm_pkg::t_cand_grid r_s2_match, r_s2_bt;
    logic [3:0]          r_s2_held, r_s2_only, r_s2_bass;
    logic [2:0]          r_s2_allow;
    ctm_pkg::t_score     r_s2_score [ctm_pkg::NUM_BINS];

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_match <= n_s2_match;
            r_s2_bt    <= n_s2_bt;
            r_s2_held  <= n_s2_held;
            r_s2_only  <= n_s2_only;
            r_s2_bass  <= n_s2_bass;
            r_s2_allow <= n_s2_allow;
            r_s2_score <= n_s2_score;
        end
    end

    // Stage 3: earliest candidate in each bin.
    ctm_pkg::t_pick n_s3_pick [ctm_pkg::NUM_BINS];

    for (genvar c = 0; c < ctm_pkg::NUM_BINS; c++) begin : g_bin
        localparam int         TONES = c / 2 + 2;
        localparam logic       BT    = (c % 2) == 1;
        localparam logic [1:0] LEN   = 2'(TONES - 1);

        ctm_pkg::t_cand_grid bin_cand;

        always_comb begin
            for (int r = 0; r < ctm_pkg::NUM_CLASSES; r++) begin
                for (int q = 0; q < ctm_pkg::NUM_TMPL; q++) begin
                    bin_cand[r][q] = r_s2_match[r][q] && (r_s2_bt[r][q] == BT)
                                   && (ctm_pkg::tmpl_len(4'(q)) == LEN)
                                   && r_s2_allow[TONES-2];
                end
            end
        end

        ctm_first u_first (
            .i_cand (bin_cand),
            .o_pick (n_s3_pick[c])
        );
    end

    ctm_pkg::t_pick  r_s3_pick  [ctm_pkg::NUM_BINS];
    ctm_pkg::t_score r_s3_score [ctm_pkg::NUM_BINS];
    logic [3:0]      r_s3_held, r_s3_only, r_s3_bass;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_pick  <= n_s3_pick;
            r_s3_score <= r_s2_score;
            r_s3_held  <= r_s2_held;
            r_s3_only  <= r_s2_only;
            r_s3_bass  <= r_s2_bass;
        end
    end

    // Stage 4: best bin by score, then tone count, then candidate order.
    logic              b_have;
    ctm_pkg::t_score   b_score;
    logic [2:0]        b_tones;
    ctm_pkg::t_pclass  b_root;
    ctm_pkg::t_quality b_q;

    always_comb begin
        logic [2:0] tones;
        logic       better;
        b_have  = 1'b0;
        b_score = '0;
        b_tones = '0;
        b_root  = '0;
        b_q     = '0;
        for (int c = 0; c < ctm_pkg::NUM_BINS; c++) begin
            tones  = 3'(c / 2 + 2);
            better = !b_have || (r_s3_score[c] > b_score)
                   || ((r_s3_score[c] == b_score) && (tones > b_tones))
                   || ((r_s3_score[c] == b_score) && (tones == b_tones)
                       && ({r_s3_pick[c].root, r_s3_pick[c].quality} < {b_root, b_q}));
            if (r_s3_pick[c].found && better) begin
                b_have  = 1'b1;
                b_score = r_s3_score[c];
                b_tones = tones;
                b_root  = r_s3_pick[c].root;
                b_q     = r_s3_pick[c].quality;
            end
        end
    end

    // Inversion of the winner: position of the bass among the chord tones,
    // with a bass outside the chord reported as first inversion.
    logic [1:0] b_inv;

    always_comb begin
        logic [2:0][3:0] ivs;
        logic [1:0]      len;
        ivs   = ctm_pkg::tmpl_ivs(b_q);
        len   = ctm_pkg::tmpl_len(b_q);
        b_inv = 2'd1;
        for (int k = 2; k >= 0; k--) begin
            if ((2'(k) < len) && (ctm_pkg::pc_add(b_root, ivs[k]) == r_s3_bass)) begin
                b_inv = 2'(k + 1);
            end
        end
        if (r_s3_bass == b_root) begin
            b_inv = 2'd0;
        end
        if (b_inv > len) begin
            b_inv = len;
        end
    end

    // Result assembly.
    ctm_pkg::t_kind    n_out_kind;
    ctm_pkg::t_pclass  n_out_root, n_out_bass;
    ctm_pkg::t_quality n_out_quality;
    logic [1:0]        n_out_inv;
    logic [3:0]        n_out_tones;
    ctm_pkg::t_score   n_out_score;

    always_comb begin
        n_out_kind    = ctm_pkg::KIND_EMPTY;
        n_out_root    = '0;
        n_out_bass    = '0;
        n_out_quality = '0;
        n_out_inv     = '0;
        n_out_tones   = '0;
        n_out_score   = '0;
        if (r_s3_held == 4'd1) begin
            n_out_kind  = ctm_pkg::KIND_SINGLE;
            n_out_root  = r_s3_only;
            n_out_bass  = r_s3_only;
            n_out_tones = 4'd1;
        end else if (r_s3_held != 4'd0) begin
            if (b_have) begin
                n_out_kind    = ctm_pkg::KIND_CHORD;
                n_out_root    = b_root;
                n_out_bass    = r_s3_bass;
                n_out_quality = b_q;
                n_out_inv     = b_inv;
                n_out_tones   = {1'b0, b_tones};
                n_out_score   = b_score;
            end else begin
                n_out_kind  = ctm_pkg::KIND_UNMATCHED;
                n_out_root  = r_s3_bass;
                n_out_bass  = r_s3_bass;
                n_out_tones = r_s3_held;
            end
        end
    end

    ctm_pkg::t_kind    r_out_kind;
    ctm_pkg::t_pclass  r_out_root, r_out_bass;
    ctm_pkg::t_quality r_out_quality;
    logic [1:0]        r_out_inv;
    logic [3:0]        r_out_tones;
    ctm_pkg::t_score   r_out_score;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out_kind    <= n_out_kind;
            r_out_root    <= n_out_root;
            r_out_bass    <= n_out_bass;
            r_out_quality <= n_out_quality;
            r_out_inv     <= n_out_inv;
            r_out_tones   <= n_out_tones;
            r_out_score   <= n_out_score;
        end
    end

    assign o_result_kind  = r_out_kind;
    assign o_root_class   = r_out_root;
    assign o_bass_out     = r_out_bass;
    assign o_quality_code = r_out_quality;
    assign o_inversion    = r_out_inv;
    assign o_tone_count   = r_out_tones;
    assign o_best_score   = r_out_score;

`ifndef SYNTHESIS
    // The pipeline is empty right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A matched chord has two to four tones.
    a_chord_tones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == ctm_pkg::KIND_CHORD))
        |-> ((o_tone_count >= 4'd2) && (o_tone_count <= 4'd4)))
        else $error("chord with bad tone count");

    // The inversion never reaches past the template's tones.
    a_inv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == ctm_pkg::KIND_CHORD))
        |-> ({2'b00, o_inversion} < o_tone_count))
        else $error("inversion beyond template");

    // Results other than a chord carry no score, no quality and no inversion.
    a_no_chord_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind != ctm_pkg::KIND_CHORD))
        |-> ((o_best_score == 11'sd0) && (o_quality_code == 4'd0)
             && (o_inversion == 2'd0)))
        else $error("score or quality on a non-chord result");

    // A chord quality is always one of the eleven templates.
    a_quality_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quality_code < 4'd11))
        else $error("quality code out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/chord_result_checker.sv =====
`timescale 1ns / 100ps

module chord_result_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration writes, as seen on the block's port
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [5:0]  i_cfg_wdata,
    // Input item channel
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [11:0] i_held_mask,
    input  wire  [3:0]  i_bass_class,
    // Result item channel
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [1:0]  i_result_kind,
    input  wire  [3:0]  i_root_class,
    input  wire  [3:0]  i_bass_out,
    input  wire  [3:0]  i_quality_code,
    input  wire  [1:0]  i_inversion,
    input  wire  [3:0]  i_tone_count,
    input  wire signed [10:0] i_best_score,
    output int          o_fail_count,
    output int          o_pending
);

    // Chord shapes rooted at C, one bit per pitch class, in search order:
    // maj7, m7, dom7, m7b5, major, minor, dim, aug, sus2, sus4, power.
    localparam logic [10:0][11:0] CHORD_SHAPES = {
        12'h081, 12'h0A1, 12'h085, 12'h111, 12'h049, 12'h089,
        12'h091, 12'h449, 12'h491, 12'h489, 12'h891
    };

    typedef struct packed {
        ctm_pkg::t_kind    kind;
        ctm_pkg::t_pclass  root;
        ctm_pkg::t_pclass  bass;
        ctm_pkg::t_quality quality;
        logic [1:0]        inversion;
        logic [3:0]        tones;
        ctm_pkg::t_score   score;
    } t_chord_result;

    // Local copy of the scoring registers.
    logic [3:0] cfg_max_extras;
    logic [5:0] cfg_tone_weight;
    logic [5:0] cfg_extra_penalty;
    logic [5:0] cfg_clean_bonus;
    logic [5:0] cfg_bass_bonus;
    logic [5:0] cfg_inversion_bonus;

    t_chord_result chord_queue[$];

    // Moves a shape up by a number of semitones, wrapping at the octave.
    function automatic logic [11:0] rotate_up(input logic [11:0] shape, input int steps);
        logic [23:0] twice;
        twice = {shape, shape} << steps;
        return twice[23:12];
    endfunction

    // Works out the result that one held mask and bass should produce.
    function automatic t_chord_result name_chord(input logic [11:0] mask,
                                                 input logic [3:0] bass_raw);
        t_chord_result res;
        logic [3:0]    bass;
        logic [11:0]   shape;
        logic [11:0]   below;
        int            held, tones, extras, span, inv, score;
        int            best_score, best_tones, best_inv;
        bit            found, bass_tone;
        res = '0;
        found = 1'b0;
        best_score = 0;
        best_tones = 0;
        best_inv = 0;
        bass = (bass_raw >= 4'd12) ? bass_raw - 4'd12 : bass_raw;
        held = $countones(mask);

        if (held == 0) begin
            res.kind = ctm_pkg::KIND_EMPTY;
            return res;
        end

        // A lone note reports itself as root and bass.
        if (held == 1) begin
            res.kind = ctm_pkg::KIND_SINGLE;
            for (int r = 0; r < 12; r++) begin
                if (mask[r]) begin
                    res.root = 4'(r);
                    res.bass = 4'(r);
                end
            end
            res.tones = 4'd1;
            return res;
        end

        // Try every held root against every shape; keep the best score.
        for (int r = 0; r < 12; r++) begin
            if (!mask[r])
                continue;
            for (int q = 0; q < 11; q++) begin
                shape = rotate_up(CHORD_SHAPES[q], r);
                if ((mask & shape) != shape)
                    continue;
                tones = $countones(CHORD_SHAPES[q]);
                extras = held - tones;
                if (extras > int'(cfg_max_extras))
                    continue;
                span = (int'(bass) + 12 - r) % 12;
                bass_tone = CHORD_SHAPES[q][span];
                below = (12'd1 << span) - 12'd1;
                // Position of the bass among the chord tones; a slash note counts as one.
                if (span == 0)
                    inv = 0;
                else if (bass_tone)
                    inv = $countones(CHORD_SHAPES[q] & below);
                else
                    inv = 1;
                score = tones * int'(cfg_tone_weight) - extras * int'(cfg_extra_penalty);
                if (extras == 0)
                    score += int'(cfg_clean_bonus);
                if (bass_tone)
                    score += int'(cfg_bass_bonus) + int'(cfg_inversion_bonus);
                if (!found || score > best_score ||
                    (score == best_score && tones > best_tones)) begin
                    found = 1'b1;
                    best_score = score;
                    best_tones = tones;
                    best_inv = inv;
                    res.root = 4'(r);
                    res.quality = 4'(q);
                end
            end
        end

        if (!found) begin
            res = '0;
            res.kind = ctm_pkg::KIND_UNMATCHED;
            res.root = bass;
            res.bass = bass;
            res.tones = 4'(held);
            return res;
        end

        if (best_inv > best_tones - 1)
            best_inv = best_tones - 1;
        res.kind = ctm_pkg::KIND_CHORD;
        res.bass = bass;
        res.inversion = 2'(best_inv);
        res.tones = 4'(best_tones);
        res.score = ctm_pkg::t_score'(best_score);
        return res;
    endfunction

    task automatic check_field(input string field, input logic signed [11:0] want,
                               input logic signed [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_fail_count++;
        end
    endtask

    // Track configuration, queue predictions and compare results at each edge.
    always @(posedge i_clk) begin : watch
        t_chord_result want;
        if (!i_rst_n) begin
            cfg_max_extras      = ctm_pkg::RST_MAX_EXTRAS;
            cfg_tone_weight     = ctm_pkg::RST_TONE_WEIGHT;
            cfg_extra_penalty   = ctm_pkg::RST_EXTRA_PENALTY;
            cfg_clean_bonus     = ctm_pkg::RST_CLEAN_BONUS;
            cfg_bass_bonus      = ctm_pkg::RST_BASS_BONUS;
            cfg_inversion_bonus = ctm_pkg::RST_INVERSION_BONUS;
            chord_queue.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (ctm_pkg::t_cfg_idx'(i_cfg_index))
                    ctm_pkg::CFG_MAX_EXTRAS:      cfg_max_extras      = i_cfg_wdata[3:0];
                    ctm_pkg::CFG_TONE_WEIGHT:     cfg_tone_weight     = i_cfg_wdata;
                    ctm_pkg::CFG_EXTRA_PENALTY:   cfg_extra_penalty   = i_cfg_wdata;
                    ctm_pkg::CFG_CLEAN_BONUS:     cfg_clean_bonus     = i_cfg_wdata;
                    ctm_pkg::CFG_BASS_BONUS:      cfg_bass_bonus      = i_cfg_wdata;
                    ctm_pkg::CFG_INVERSION_BONUS: cfg_inversion_bonus = i_cfg_wdata;
                    default: ;
                endcase
            end

            // Results are checked before new items are queued, so an unexpected
            // result cannot pair with an item accepted on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (chord_queue.size() == 0) begin
                    $error("result item arrived with no item outstanding");
                    o_fail_count++;
                end else begin
                    want = chord_queue.pop_front();
                    check_field("result_kind", want.kind, i_result_kind);
                    check_field("root_class", want.root, i_root_class);
                    check_field("bass_out", want.bass, i_bass_out);
                    check_field("quality_code", want.quality, i_quality_code);
                    check_field("inversion", want.inversion, i_inversion);
                    check_field("tone_count", want.tones, i_tone_count);
                    check_field("best_score", want.score, i_best_score);
                end
            end

            if (i_in_valid && !i_in_stall)
                chord_queue.push_back(name_chord(i_held_mask, i_bass_class));
        end
        o_pending <= chord_queue.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int ITEMS_PER_SETTING = 64;
    localparam int NUM_SETTINGS      = 8;
    localparam int SETTLE_CYCLES     = 8;
    localparam int CYCLE_LIMIT       = 400000;

    // Chord shapes rooted at C, indexed by quality in search order.
    localparam logic [10:0][11:0] CHORD_SHAPES = {
        12'h081, 12'h0A1, 12'h085, 12'h111, 12'h049, 12'h089,
        12'h091, 12'h449, 12'h491, 12'h489, 12'h891
    };

    typedef enum int {
        Q_MAJ7, Q_MIN7, Q_DOM7, Q_HALFDIM7, Q_MAJOR, Q_MINOR,
        Q_DIM, Q_AUG, Q_SUS2, Q_SUS4, Q_POWER
    } t_chord_quality;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        cfg_wr_en  = 1'b0;
    ctm_pkg::t_cfg_idx cfg_index = ctm_pkg::CFG_MAX_EXTRAS;
    logic [5:0]  cfg_wdata  = '0;
    logic        in_valid   = 1'b0;
    logic [11:0] held_mask  = '0;
    logic [3:0]  bass_class = '0;
    logic        out_stall  = 1'b0;

    wire         in_stall;
    wire         out_valid;
    wire  [1:0]  result_kind;
    wire  [3:0]  root_class;
    wire  [3:0]  bass_out;
    wire  [3:0]  quality_code;
    wire  [1:0]  inversion;
    wire  [3:0]  tone_count;
    wire signed [10:0] best_score;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    bit  tx_steady = 1'b0;

    chord_template_matcher u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_held_mask    (held_mask),
        .i_bass_class   (bass_class),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_result_kind  (result_kind),
        .o_root_class   (root_class),
        .o_bass_out     (bass_out),
        .o_quality_code (quality_code),
        .o_inversion    (inversion),
        .o_tone_count   (tone_count),
        .o_best_score   (best_score)
    );

    chord_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_held_mask    (held_mask),
        .i_bass_class   (bass_class),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result_kind  (result_kind),
        .i_root_class   (root_class),
        .i_bass_out     (bass_out),
        .i_quality_code (quality_code),
        .i_inversion    (inversion),
        .i_tone_count   (tone_count),
        .i_best_score   (best_score),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("chord_template_matcher test failed");
            $finish;
        end
    end

    function automatic logic [11:0] rotate_up(input logic [11:0] shape, input int steps);
        logic [23:0] twice;
        twice = {shape, shape} << steps;
        return twice[23:12];
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Result side: stretches of ready interleaved with stalls of random length.
    initial begin : result_stall
        int left;
        bit stalled;
        left = 0;
        stalled = 1'b0;
        forever begin
            @(posedge clk);
            if (left == 0) begin
                if (stalled) begin
                    stalled = 1'b0;
                    left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                        : $urandom_range(1, 12);
                end else begin
                    left = pick_gap();
                    stalled = (left != 0);
                    if (!stalled)
                        left = $urandom_range(1, 12);
                end
            end
            left--;
            out_stall <= stalled;
        end
    end

    // Presents one item and holds it until the block takes it.
    task automatic send_item(input logic [11:0] mask, input logic [3:0] bass);
        int gap;
        in_valid <= 1'b1;
        held_mask <= mask;
        bass_class <= bass;
        do @(posedge clk); while (in_stall);
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every result has come back and the pipeline has emptied.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [5:0] max_extras, input logic [5:0] tone_w,
                                  input logic [5:0] penalty, input logic [5:0] clean,
                                  input logic [5:0] bass_b, input logic [5:0] inv_b);
        logic [5:0][5:0] values;
        values = {inv_b, bass_b, clean, penalty, tone_w, max_extras};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ctm_pkg::t_cfg_idx'(i);
            cfg_wdata <= values[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly real chords with a few extra notes, plus noise and broken chords.
    task automatic next_random_item(output logic [11:0] mask, output logic [3:0] bass);
        logic [11:0] shape;
        int          roll, root, tone;
        roll = $urandom_range(0, 9);
        root = $urandom_range(0, 11);
        shape = rotate_up(CHORD_SHAPES[$urandom_range(0, 10)], root);
        mask = shape;
        bass = 4'($urandom_range(0, 15));
        case (roll)
            6: mask = 12'($urandom);
            7: mask = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'd1 << $urandom_range(0, 11);
            8: mask = shape | rotate_up(CHORD_SHAPES[$urandom_range(0, 10)],
                                        $urandom_range(0, 11));
            9: mask[root] = 1'b0;
            default: begin
                repeat ($urandom_range(0, 3)) mask[$urandom_range(0, 11)] = 1'b1;
                // Bass on the root, on some chord tone, or anywhere.
                case ($urandom_range(0, 3))
                    0: bass = 4'(root);
                    1, 2: begin
                        do tone = $urandom_range(0, 11); while (!shape[tone]);
                        bass = 4'(tone);
                        if (tone < 4 && $urandom_range(0, 3) == 0)
                            bass = bass + 4'd12;
                    end
                    default: ;
                endcase
            end
        endcase
    endtask

    initial begin : stimulus
        logic [11:0] mask;
        logic [3:0]  bass;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings.
        send_item(12'h000, 4'd0);
        send_item(12'h000, 4'd15);
        send_item(12'h800, 4'd3);
        send_item(12'h001, 4'd15);
        send_item(12'hFFF, 4'd0);
        send_item(12'hFFF, 4'd15);
        send_item(12'h003, 4'd13);
        send_item(rotate_up(CHORD_SHAPES[Q_MAJ7], 0), 4'd4);
        send_item(rotate_up(CHORD_SHAPES[Q_MAJ7], 0), 4'd11);
        send_item(rotate_up(CHORD_SHAPES[Q_MAJOR], 0), 4'd7);
        send_item(rotate_up(CHORD_SHAPES[Q_MAJOR], 0), 4'd2);
        send_item(rotate_up(CHORD_SHAPES[Q_POWER], 7), 4'd12);
        send_item(rotate_up(CHORD_SHAPES[Q_MIN7], 9), 4'd9);
        send_item(rotate_up(CHORD_SHAPES[Q_DOM7], 7), 4'd5);
        send_item(rotate_up(CHORD_SHAPES[Q_HALFDIM7], 11), 4'd14);
        send_item(rotate_up(CHORD_SHAPES[Q_MINOR], 4), 4'd4);
        send_item(rotate_up(CHORD_SHAPES[Q_DIM], 1), 4'd7);
        send_item(rotate_up(CHORD_SHAPES[Q_AUG], 0), 4'd8);
        send_item(rotate_up(CHORD_SHAPES[Q_SUS2], 0), 4'd0);
        send_item(rotate_up(CHORD_SHAPES[Q_SUS4], 5), 4'd0);
        send_item(rotate_up(CHORD_SHAPES[Q_MAJOR], 0) | 12'h004, 4'd0);
        send_item(rotate_up(CHORD_SHAPES[Q_MAJOR], 0) | 12'h204, 4'd0);
        send_item(rotate_up(CHORD_SHAPES[Q_MAJOR], 0) | 12'hA04, 4'd9);

        // Random items under a series of register settings, extremes included.
        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            wait_idle();
            case (setting)
                0: write_settings(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
                1: write_settings({2'($urandom), 4'd15}, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63);
                2: write_settings(6'd12, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0);
                3: write_settings(6'd1, 6'd1, 6'd63, 6'd63, 6'd63, 6'd63);
                7: write_settings({2'd0, ctm_pkg::RST_MAX_EXTRAS}, ctm_pkg::RST_TONE_WEIGHT,
                                  ctm_pkg::RST_EXTRA_PENALTY, ctm_pkg::RST_CLEAN_BONUS,
                                  ctm_pkg::RST_BASS_BONUS, ctm_pkg::RST_INVERSION_BONUS);
                default: write_settings(6'($urandom), 6'($urandom), 6'($urandom),
                                        6'($urandom), 6'($urandom), 6'($urandom));
            endcase
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (n % 32 == 0)
                    tx_steady = ($urandom_range(0, 3) == 0);
                next_random_item(mask, bass);
                send_item(mask, bass);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("chord_template_matcher test passed");
        else
            $display("chord_template_matcher test failed");
        $finish;
    end

endmodule
